FILE: rtl/firq_pkg.sv
package firq_pkg;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int OPCODE_W    = 2;
    localparam int TAP_INDEX_W = 4;
    localparam int FRAC_BITS   = 15;

    // Saturation limits of the output sample
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // Item opcodes (code 3 is unused and ignored)
    typedef enum logic [OPCODE_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    // Per-item control shared by every cell in the chain
    typedef struct packed {
        logic shift;      // sample transfer: taps move one cell down
        logic clear;      // zero all taps
        logic load_prod;  // product register may take a new value
    } t_cell_ctrl;

    // Default symmetric lowpass coefficients
    localparam int DEFAULT_COUNT = 16;
    localparam logic signed [SAMPLE_W-1:0] LOWPASS [DEFAULT_COUNT] = '{
        -16'sd1586,  16'sd1037,  16'sd2173,   16'sd528,
        -16'sd2496, -16'sd1370,  16'sd6023,  16'sd13670,
         16'sd13670, 16'sd6023, -16'sd1370, -16'sd2496,
         16'sd528,   16'sd2173,  16'sd1037, -16'sd1586
    };

    // Reset coefficient of a tap; taps past the table start at zero
    function automatic logic signed [SAMPLE_W-1:0] default_coef(input int idx);
        logic signed [SAMPLE_W-1:0] v;
        v = '0;
        if (idx < DEFAULT_COUNT) begin
            v = LOWPASS[idx[3:0]];
        end
        return v;
    endfunction

endpackage

FILE: rtl/fir_filter_q15_saturating_top.sv
// FIR filter, TAPS taps, signed 16-bit samples, Q15 coefficients, saturating.
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   sample  - shifts i_sample_in into the taps and yields one filtered output
//   coef    - writes i_tap_weight to tap i_tap_index (ignored if out of range)
//   clear   - zeroes all taps
// Unused opcode 3 does nothing. Only sample items produce an output transfer
// (o_out_valid / i_out_stall) carrying o_sample_out and o_clipped.
// Throughput: one item per clock while o_in_stall is low. Each cell holds a
// tap and a coefficient and multiplies in the transfer cycle; products then
// go through a registered adder tree of clog2(TAPS) levels and a
// saturation/output register.
// While the receiver stalls, results collect in the empty pipeline slots;
// o_in_stall rises only once every slot holds a result. Results keep order.
// Reset clears the taps, loads the default lowpass coefficients and empties
// the pipeline; no reset sweep is needed.
module fir_filter_q15_saturating_top #(
    parameter int TAPS = 16
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_in_valid,
    output logic                                           o_in_stall,
    input  logic [firq_pkg::OPCODE_W-1:0]                  i_opcode,
    input  logic signed [firq_pkg::SAMPLE_W-1:0]           i_sample_in,
    input  logic [firq_pkg::TAP_INDEX_W-1:0]               i_tap_index,
    input  logic signed [firq_pkg::SAMPLE_W-1:0]           i_tap_weight,
    output logic                                           o_out_valid,
    input  logic                                           i_out_stall,
    output logic signed [firq_pkg::SAMPLE_W-1:0]           o_sample_out,
    output logic                                           o_clipped
);

    localparam int L  = $clog2(TAPS);
    localparam int W  = firq_pkg::PROD_W + L;
    localparam int SW = W - firq_pkg::FRAC_BITS;

    localparam logic signed [SW-1:0] SAT_HI = SW'(firq_pkg::SAMPLE_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(firq_pkg::SAMPLE_MIN);

    logic                                   w_accept;
    logic                                   w_prod_en;
    logic                                   w_tree_ready;
    logic                                   w_out_en;
    logic                                   w_is_sample;
    logic                                   w_is_coef;
    logic                                   w_is_clear;
    firq_pkg::t_cell_ctrl                   w_ctrl;
    logic signed [firq_pkg::SAMPLE_W-1:0]   w_chain [TAPS];
    logic signed [firq_pkg::PROD_W-1:0]     w_prod [TAPS];
    logic                                   r_pv;
    logic                                   w_sum_vld;
    logic signed [W-1:0]                    w_sum;
    logic signed [SW-1:0]                   w_scaled;
    logic signed [firq_pkg::SAMPLE_W-1:0]   n_sample_out;
    logic                                   n_clipped;
    logic                                   r_ovld;
    logic signed [firq_pkg::SAMPLE_W-1:0]   r_sample_out;
    logic                                   r_clipped;

    // Opcode decode
    always_comb begin
        w_is_sample = 1'b0;
        w_is_coef   = 1'b0;
        w_is_clear  = 1'b0;
        unique case (i_opcode)
            firq_pkg::OP_SAMPLE: w_is_sample = 1'b1;
            firq_pkg::OP_COEF:   w_is_coef   = 1'b1;
            firq_pkg::OP_CLEAR:  w_is_clear  = 1'b1;
            default: ;
        endcase
    end

    // Flow control: product stage moves when empty or the tree takes it
    assign w_prod_en  = !r_pv || w_tree_ready;
    assign o_in_stall = !w_prod_en;
    assign w_accept   = i_in_valid && w_prod_en;

    assign w_ctrl.shift     = w_accept && w_is_sample;
    assign w_ctrl.clear     = w_accept && w_is_clear;
    assign w_ctrl.load_prod = w_prod_en;

    // Chain of cells; cell 0 takes the incoming sample
    assign w_chain[0] = i_sample_in;

    genvar i;
    generate
        for (i = 0; i < TAPS; i++) begin : g_cell
            logic w_wr;
            if (i < (1 << firq_pkg::TAP_INDEX_W)) begin : g_addr
                assign w_wr = w_accept && w_is_coef
                              && (i_tap_index == firq_pkg::TAP_INDEX_W'(i));
            end else begin : g_noaddr
                assign w_wr = 1'b0;
            end
            if (i < TAPS - 1) begin : g_mid
                firq_cell #(.INDEX(i)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctrl    (w_ctrl),
                    .i_coef_wr (w_wr),
                    .i_coef    (i_tap_weight),
                    .i_tap_in  (w_chain[i]),
                    .o_tap     (w_chain[i+1]),
                    .o_prod    (w_prod[i])
                );
            end else begin : g_last
                firq_cell #(.INDEX(i)) u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctrl    (w_ctrl),
                    .i_coef_wr (w_wr),
                    .i_coef    (i_tap_weight),
                    .i_tap_in  (w_chain[i]),
                    .o_tap     (),
                    .o_prod    (w_prod[i])
                );
            end
        end
    endgenerate

    // Product stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_prod_en) begin
            r_pv <= w_accept && w_is_sample;
        end
    end

    // Registered adder tree
    firq_sum_tree #(.LEAVES(TAPS)) u_tree (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_leaf_vld  (r_pv),
        .i_leaf      (w_prod),
        .i_out_ready (w_out_en),
        .o_in_ready  (w_tree_ready),
        .o_sum_vld   (w_sum_vld),
        .o_sum       (w_sum)
    );

    // Floor shift by 15, then clamp to 16 bits
    assign w_scaled = SW'(w_sum >>> firq_pkg::FRAC_BITS);

    always_comb begin
        n_sample_out = w_scaled[firq_pkg::SAMPLE_W-1:0];
        n_clipped    = 1'b0;
        if (w_scaled > SAT_HI) begin
            n_sample_out = firq_pkg::SAMPLE_MAX;
            n_clipped    = 1'b1;
        end else if (w_scaled < SAT_LO) begin
            n_sample_out = firq_pkg::SAMPLE_MIN;
            n_clipped    = 1'b1;
        end
    end

    // Output register
    assign w_out_en = !r_ovld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_en) begin
            r_ovld <= w_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en) begin
            r_sample_out <= n_sample_out;
            r_clipped    <= n_clipped;
        end
    end

    assign o_out_valid  = r_ovld;
    assign o_sample_out = r_sample_out;
    assign o_clipped    = r_clipped;

endmodule

FILE: rtl/firq_cell.sv
module firq_cell #(
    parameter int INDEX = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  firq_pkg::t_cell_ctrl                   i_ctrl,
    input  logic                                   i_coef_wr,
    input  logic signed [firq_pkg::SAMPLE_W-1:0]   i_coef,
    input  logic signed [firq_pkg::SAMPLE_W-1:0]   i_tap_in,
    output logic signed [firq_pkg::SAMPLE_W-1:0]   o_tap,
    output logic signed [firq_pkg::PROD_W-1:0]     o_prod
);

    logic signed [firq_pkg::SAMPLE_W-1:0] r_tap;
    logic signed [firq_pkg::SAMPLE_W-1:0] n_tap;
    logic signed [firq_pkg::SAMPLE_W-1:0] r_coef;
    logic signed [firq_pkg::PROD_W-1:0]   r_prod;
    logic signed [firq_pkg::PROD_W-1:0]   w_prod;

    // Tap update: clear wins, a sample shifts in the neighbor's tap
    always_comb begin
        n_tap = r_tap;
        if (i_ctrl.clear) begin
            n_tap = '0;
        end else if (i_ctrl.shift) begin
            n_tap = i_tap_in;
        end
    end

    // Product against the tap value after the shift
    assign w_prod = firq_pkg::PROD_W'(r_coef) * firq_pkg::PROD_W'(i_tap_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap  <= '0;
            r_coef <= firq_pkg::default_coef(INDEX);
        end else begin
            r_tap <= n_tap;
            if (i_coef_wr) begin
                r_coef <= i_coef;
            end
        end
    end

    // Product register, payload only
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_prod) begin
            r_prod <= w_prod;
        end
    end

    assign o_tap  = r_tap;
    assign o_prod = r_prod;

endmodule

FILE: rtl/firq_sum_tree.sv
module firq_sum_tree #(
    parameter int LEAVES = 16
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_leaf_vld,
    input  logic signed [firq_pkg::PROD_W-1:0]                    i_leaf [LEAVES],
    input  logic                                                  i_out_ready,
    output logic                                                  o_in_ready,
    output logic                                                  o_sum_vld,
    output logic signed [firq_pkg::PROD_W+$clog2(LEAVES)-1:0]     o_sum
);

    localparam int L = $clog2(LEAVES);
    localparam int N = 1 << L;
    localparam int W = firq_pkg::PROD_W + L;

    logic signed [W-1:0] w_leaf [N];
    logic signed [W-1:0] r_node [1:N-1];
    logic [L:1]          r_vld;
    logic [L+1:1]        w_en;

    // Sign-extend products, zero-pad to a power of two
    genvar j;
    generate
        for (j = 0; j < N; j++) begin : g_leaf
            if (j < LEAVES) begin : g_real
                assign w_leaf[j] = W'(i_leaf[j]);
            end else begin : g_pad
                assign w_leaf[j] = '0;
            end
        end
    endgenerate

    // Per-level enable: a level moves when empty or when the next one moves
    always_comb begin
        w_en[L+1] = i_out_ready;
        for (int l = L; l >= 1; l--) begin
            w_en[l] = !r_vld[l] || w_en[l+1];
        end
    end

    // Valid bits follow the data through the levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_leaf_vld;
            end
            for (int l = 2; l <= L; l++) begin
                if (w_en[l]) begin
                    r_vld[l] <= r_vld[l-1];
                end
            end
        end
    end

    // Heap-ordered adder nodes; node k has children 2k and 2k+1
    genvar k;
    generate
        for (k = 1; k < N; k++) begin : g_node
            localparam int DEPTH = $clog2(k + 1) - 1;
            localparam int LVL   = L - DEPTH;
            logic signed [W-1:0] w_a;
            logic signed [W-1:0] w_b;
            if (2 * k >= N) begin : g_from_leaf
                assign w_a = w_leaf[2*k-N];
                assign w_b = w_leaf[2*k+1-N];
            end else begin : g_from_node
                assign w_a = r_node[2*k];
                assign w_b = r_node[2*k+1];
            end
            always_ff @(posedge i_clk) begin
                if (w_en[LVL]) begin
                    r_node[k] <= w_a + w_b;
                end
            end
        end
    endgenerate

    assign o_in_ready = w_en[1];
    assign o_sum_vld  = r_vld[L];
    assign o_sum      = r_node[1];

endmodule
